/* design/pbr_pkg.sv */
// package for the base relocation engine: result kinds, entry type codes,
// header phase encoding and field widths; no dependencies
`default_nettype none

package pbr_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned PAGE_W   = 32;
    localparam int unsigned COUNT_W  = 31;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned TYPE_W   = 4;
    localparam int unsigned KIND_W   = 2;

    localparam logic [PAGE_W-1:0] HEADER_BYTES = 32'd8;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_ADD32 = 2'd0;
    localparam kind_t KIND_ADD64 = 2'd1;
    localparam kind_t KIND_ERROR = 2'd2;

    typedef logic [TYPE_W-1:0] reloc_type_t;
    localparam reloc_type_t TYPE_ABSOLUTE = 4'd0;
    localparam reloc_type_t TYPE_HIGHLOW  = 4'd3;
    localparam reloc_type_t TYPE_DIR64    = 4'd10;

    // config register indexes
    localparam logic REG_LOAD_BASE   = 1'b0;
    localparam logic REG_IMAGE_DELTA = 1'b1;

    typedef enum logic [4:0] {
        PH_PAGE_LO = 5'b00001,
        PH_PAGE_HI = 5'b00010,
        PH_SIZE_LO = 5'b00100,
        PH_SIZE_HI = 5'b01000,
        PH_ENTRY   = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

/* design/pe_base_relocation_engine_core.sv */
// PE/COFF base relocation engine top level: directory word parser and patch
// command output register; depends on pbr_pkg
`default_nettype none

// Takes the relocation directory one 16-bit word per request and returns at most
// one patch command per word. The header/entry parser and the 64-bit address add
// sit between the state registers and the result register, so a word can be
// accepted on every clock while the result slot is empty or being drained the same
// cycle. A result is registered and appears in the cycle after its word. An unknown
// entry type returns one error result and all later words are swallowed until reset;
// with image_delta at zero words are parsed but nothing comes out. The user must
// write load_base and image_delta via the config port only while idle (unenforced).
module pe_base_relocation_engine_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire  [pbr_pkg::ADDR_W-1:0]   cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [pbr_pkg::WORD_W-1:0]   s_reloc_word,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pbr_pkg::KIND_W-1:0]   m_patch_kind,
    output logic [pbr_pkg::ADDR_W-1:0]   m_patch_address,
    output logic [pbr_pkg::ADDR_W-1:0]   m_patch_addend,
    output logic [pbr_pkg::TYPE_W-1:0]   m_bad_type
);
    import pbr_pkg::*;

    logic [ADDR_W-1:0]  load_base_reg;
    logic [ADDR_W-1:0]  image_delta_reg;

    phase_t             phase_reg, phase_next;
    logic [PAGE_W-1:0]  page_offset_reg, page_offset_next;
    logic [COUNT_W-1:0] entries_left_reg, entries_left_next;
    logic [WORD_W-1:0]  size_low_reg, size_low_next;
    logic               error_stop_reg, error_stop_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [ADDR_W-1:0]  out_address_reg;
    logic [ADDR_W-1:0]  out_addend_reg;
    reloc_type_t        out_type_reg;

    logic               in_accept;
    logic               res_valid;
    kind_t              res_kind;
    logic [ADDR_W-1:0]  res_address;
    logic [ADDR_W-1:0]  res_addend;
    reloc_type_t        entry_type;
    logic [PAGE_W-1:0]  block_size;
    logic [PAGE_W-1:0]  size_minus_hdr;
    logic [COUNT_W-1:0] entries_dec;

    assign s_ready   = !out_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    assign entry_type     = s_reloc_word[WORD_W-1 -: TYPE_W];
    assign block_size     = {s_reloc_word, size_low_reg};
    assign size_minus_hdr = block_size - HEADER_BYTES;
    assign entries_dec    = entries_left_reg - 1'b1;

    assign res_address = load_base_reg + {{(ADDR_W-PAGE_W){1'b0}}, page_offset_reg}
                       + {{(ADDR_W-OFFSET_W){1'b0}}, s_reloc_word[OFFSET_W-1:0]};

    // parser state update and result for the word at the input
    always_comb begin
        phase_next        = phase_reg;
        page_offset_next  = page_offset_reg;
        entries_left_next = entries_left_reg;
        size_low_next     = size_low_reg;
        error_stop_next   = error_stop_reg;
        res_valid         = 1'b0;
        res_kind          = KIND_ERROR;
        res_addend        = '0;
        if (!error_stop_reg) begin
            unique case (phase_reg)
                PH_PAGE_HI: begin
                    page_offset_next = {s_reloc_word, page_offset_reg[WORD_W-1:0]};
                    phase_next       = PH_SIZE_LO;
                end
                PH_SIZE_LO: begin
                    size_low_next = s_reloc_word;
                    phase_next    = PH_SIZE_HI;
                end
                PH_SIZE_HI: begin
                    // short block is header only; odd size rounds down
                    if (block_size < HEADER_BYTES) begin
                        entries_left_next = '0;
                    end else begin
                        entries_left_next = size_minus_hdr[PAGE_W-1:1];
                    end
                    phase_next = (entries_left_next == '0) ? PH_PAGE_LO : PH_ENTRY;
                end
                PH_ENTRY: begin
                    entries_left_next = entries_dec;
                    if (entries_dec == '0) begin
                        phase_next = PH_PAGE_LO;
                    end
                    if (entry_type != TYPE_ABSOLUTE && image_delta_reg != '0) begin
                        res_valid = 1'b1;
                        if (entry_type == TYPE_HIGHLOW) begin
                            res_kind   = KIND_ADD32;
                            res_addend = {{(ADDR_W-32){1'b0}}, image_delta_reg[31:0]};
                        end else if (entry_type == TYPE_DIR64) begin
                            res_kind   = KIND_ADD64;
                            res_addend = image_delta_reg;
                        end else begin
                            res_kind        = KIND_ERROR;
                            error_stop_next = 1'b1;
                        end
                    end
                end
                default: begin
                    // first header word, also taken for any unexpected phase code
                    page_offset_next = {{(PAGE_W-WORD_W){1'b0}}, s_reloc_word};
                    phase_next       = PH_PAGE_HI;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg    <= '0;
            image_delta_reg  <= '0;
            phase_reg        <= PH_PAGE_LO;
            page_offset_reg  <= '0;
            entries_left_reg <= '0;
            size_low_reg     <= '0;
            error_stop_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LOAD_BASE:   load_base_reg   <= cfg_wdata;
                    REG_IMAGE_DELTA: image_delta_reg <= cfg_wdata;
                    default:         load_base_reg   <= load_base_reg;
                endcase
            end
            if (in_accept) begin
                phase_reg        <= phase_next;
                page_offset_reg  <= page_offset_next;
                entries_left_reg <= entries_left_next;
                size_low_reg     <= size_low_next;
                error_stop_reg   <= error_stop_next;
                out_valid_reg    <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted word that yields a result
    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            out_kind_reg    <= res_kind;
            out_address_reg <= res_address;
            out_addend_reg  <= res_addend;
            out_type_reg    <= entry_type;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_patch_kind    = out_kind_reg;
    assign m_patch_address = out_address_reg;
    assign m_patch_addend  = out_addend_reg;
    assign m_bad_type      = out_type_reg;

`ifndef SYNTHESIS
    a_error_sets_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_patch_kind == KIND_ERROR |-> error_stop_reg)
        else $error("error result without error stop");

    a_entry_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ENTRY |-> entries_left_reg != '0)
        else $error("entry phase with no entries left");

    a_stop_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        error_stop_reg && in_accept |=> $stable(phase_reg) && $stable(entries_left_reg)
            && $stable(page_offset_reg))
        else $error("parser state moved after error stop");

    a_add32_addend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_patch_kind == KIND_ADD32 |-> m_patch_addend[ADDR_W-1:32] == '0)
        else $error("32-bit patch with wide addend");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_patch_kind == KIND_ADD32 || m_patch_kind == KIND_ADD64
            || m_patch_kind == KIND_ERROR)
        else $error("illegal patch kind");
`endif

endmodule

`default_nettype wire

/* sim/tb_pe_base_relocation_engine_core.sv */
// self-checking testbench for pe_base_relocation_engine_core: streams relocation
// directory words, predicts patch commands in sv and compares each result
// depends on pbr_pkg and the rtl top level only
module tb_pe_base_relocation_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pbr_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  addend;
        reloc_type_t        bad_type;
    } patch_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = REG_LOAD_BASE;
    logic [ADDR_W-1:0]   cfg_wdata    = '0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [WORD_W-1:0]   s_reloc_word = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [KIND_W-1:0]   m_patch_kind;
    logic [ADDR_W-1:0]   m_patch_address;
    logic [ADDR_W-1:0]   m_patch_addend;
    logic [TYPE_W-1:0]   m_bad_type;

    // parser mirror and register copies
    phase_t              parse_phase  = PH_PAGE_LO;
    logic [PAGE_W-1:0]   page_base    = '0;
    logic [COUNT_W-1:0]  entries_due  = '0;
    logic [WORD_W-1:0]   size_low     = '0;
    bit                  halted       = 1'b0;
    logic [ADDR_W-1:0]   load_base_copy = '0;
    logic [ADDR_W-1:0]   delta_copy     = '0;

    patch_t              pending_patches[$];
    int                  mismatch_count = 0;
    bit                  no_idle        = 1'b0;
    logic                hold_req       = 1'b0;
    int                  hold_left      = 0;

    pe_base_relocation_engine_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_reloc_word    (s_reloc_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_patch_kind    (m_patch_kind),
        .m_patch_address (m_patch_address),
        .m_patch_addend  (m_patch_addend),
        .m_bad_type      (m_bad_type)
    );

    always #5 aclk = ~aclk;

    // advance the parser by one accepted word and queue the patch it causes
    function automatic void parse_reloc_word(input logic [WORD_W-1:0] w);
        logic [PAGE_W-1:0] size;
        reloc_type_t       typ;
        patch_t            p;
        if (halted) return;
        case (parse_phase)
            PH_PAGE_HI: begin
                page_base[31:16] = w;
                parse_phase = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
                size_low = w;
                parse_phase = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
                size = {w, size_low};
                if (size < HEADER_BYTES) begin
                    entries_due = '0;
                end else begin
                    size = (size - HEADER_BYTES) >> 1;
                    entries_due = size[COUNT_W-1:0];
                end
                parse_phase = (entries_due == 0) ? PH_PAGE_LO : PH_ENTRY;
            end
            PH_ENTRY: begin
                entries_due = entries_due - 1'b1;
                if (entries_due == 0) parse_phase = PH_PAGE_LO;
                typ = w[15:12];
                if (typ == TYPE_ABSOLUTE || delta_copy == 0) return;
                p.address  = load_base_copy + {32'h0, page_base} + {52'h0, w[11:0]};
                p.bad_type = typ;
                if (typ == TYPE_HIGHLOW) begin
                    p.kind   = KIND_ADD32;
                    p.addend = {32'h0, delta_copy[31:0]};
                end else if (typ == TYPE_DIR64) begin
                    p.kind   = KIND_ADD64;
                    p.addend = delta_copy;
                end else begin
                    p.kind   = KIND_ERROR;
                    p.addend = '0;
                    halted   = 1'b1;
                end
                pending_patches.push_back(p);
            end
            default: begin
                page_base = {16'h0, w};
                parse_phase = PH_PAGE_HI;
            end
        endcase
    endfunction

    // next directory word, shaped by where the parser stands
    function automatic logic [WORD_W-1:0] next_dir_word(input bit noisy);
        int          r;
        reloc_type_t typ;
        r = $urandom_range(0, 99);
        case (parse_phase)
            PH_SIZE_LO: begin
                if (noisy && r < 50) return 16'($urandom);
                if (r < 10) return 16'($urandom_range(0, 7));
                if (r < 22) return 16'(9 + 2 * $urandom_range(0, 10));
                return 16'(8 + 2 * $urandom_range(0, 12));
            end
            PH_SIZE_HI: begin
                if (noisy && r < 20) return 16'($urandom);
                return 16'h0;
            end
            PH_ENTRY: begin
                if (noisy) typ = reloc_type_t'($urandom_range(0, 15));
                else if (r < 15) typ = TYPE_ABSOLUTE;
                else if (r < 60) typ = TYPE_HIGHLOW;
                else typ = TYPE_DIR64;
                return {typ, 12'($urandom)};
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] rand_delta();
        logic [ADDR_W-1:0] d;
        d = {$urandom, $urandom};
        if (d == 0) d = 64'h1;
        return d;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [WORD_W-1:0] w);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_reloc_word <= w;
        do @(posedge aclk); while (!s_ready);
        parse_reloc_word(w);
    endtask

    // the block holds at most one result; wait until every expected result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_patches.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] delta);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOAD_BASE;
        cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= REG_IMAGE_DELTA;
        cfg_wdata <= delta;
        @(posedge aclk);
        cfg_we <= 1'b0;
        load_base_copy = base;
        delta_copy     = delta;
    endtask

    task automatic send_words(input logic [WORD_W-1:0] words[]);
        foreach (words[i]) send_request(words[i]);
    endtask

    // reset registers: delta is zero, so nothing comes out, unknown types included
    task automatic test_zero_delta();
        send_words('{16'h1000, 16'h0000, 16'h000e, 16'h0000,
                     16'h3abc, 16'ha123, 16'h5fff});
    endtask

    // both patch kinds, filler, address wrap at the top of the space
    task automatic test_patch_kinds();
        set_config('1, '1);
        send_words('{16'hffff, 16'hffff, 16'h0010, 16'h0000,
                     16'h3fff, 16'ha000, 16'h0123, 16'hafff});
    endtask

    // zero size block is header only, odd size rounds down to one entry
    task automatic test_header_corners();
        set_config('0, 64'h8000_0000_0000_0000);
        send_words('{16'h5678, 16'h1234, 16'h0000, 16'h0000,
                     16'h0001, 16'h0000, 16'h000b, 16'h0000, 16'ha7ff});
    endtask

    task automatic test_backpressure();
        set_config({$urandom, $urandom}, rand_delta());
        no_idle = 1'b1;
        hold_req <= 1'b1;
        repeat (40) send_request(next_dir_word(1'b0));
        no_idle = 1'b0;
        // sender stops until every result is back, then resumes
        wait_drained();
        repeat (20) send_request(next_dir_word(1'b0));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config('0, 64'h7fff_ffff_ffff_ffff);
                1: set_config('1, 64'h8000_0000_0000_0000);
                2: set_config({$urandom, $urandom}, 64'h1);
                5: set_config({$urandom, $urandom}, '0);
                default: set_config({$urandom, $urandom}, rand_delta());
            endcase
            no_idle = (ph == 4);
            // last phase runs with delta zero, so any word is harmless
            repeat (240) send_request(next_dir_word(ph == 5));
            no_idle = 1'b0;
        end
    endtask

    // an unknown type returns one error, then the block swallows everything
    task automatic test_unknown_type_halt();
        reloc_type_t typ;
        set_config({$urandom, $urandom}, rand_delta());
        while (parse_phase != PH_ENTRY) send_request(next_dir_word(1'b0));
        repeat (6) send_request(next_dir_word(1'b0));
        while (parse_phase != PH_ENTRY) send_request(next_dir_word(1'b0));
        do typ = reloc_type_t'($urandom_range(1, 15));
        while (typ == TYPE_HIGHLOW || typ == TYPE_DIR64);
        send_request({typ, 12'($urandom)});
        repeat (20) send_request(next_dir_word(1'b1));
        send_request({TYPE_HIGHLOW, 12'h001});
        send_request({TYPE_DIR64, 12'h002});
    endtask

    // result side: random ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_left = 200;
            hold_req <= 1'b0;
            m_ready  <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge aclk) begin
        patch_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_patches.size() == 0) begin
                report_mismatch("unexpected result, address", m_patch_address, '0);
            end else begin
                want = pending_patches.pop_front();
                if (m_patch_kind !== want.kind)
                    report_mismatch("patch_kind", 64'(m_patch_kind), 64'(want.kind));
                if (m_patch_address !== want.address)
                    report_mismatch("patch_address", m_patch_address, want.address);
                if (m_patch_addend !== want.addend)
                    report_mismatch("patch_addend", m_patch_addend, want.addend);
                if (m_bad_type !== want.bad_type)
                    report_mismatch("bad_type", 64'(m_bad_type), 64'(want.bad_type));
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_delta();
        test_patch_kinds();
        test_header_corners();
        test_backpressure();
        test_random_traffic();
        test_unknown_type_halt();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending_patches.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
design/pbr_pkg.sv
design/pe_base_relocation_engine_core.sv
sim/tb_pe_base_relocation_engine_core.sv
